// File: design/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg: shared definitions for the largest contour centroid block
// Field widths, register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package lcc_pkg;

  // field widths
  localparam int PX_W   = 9;
  localparam int PY_W   = 8;
  localparam int AREA_W = 17;
  localparam int STEP_W = 8;
  localparam int PROD_W = PX_W + PY_W;

  // default contour length limit
  localparam int MAX_POINTS_DEF = 4096;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_Y = 2'd3;

  // configuration reset values
  localparam logic [AREA_W-1:0] MIN_AREA_RST  = 17'd4000;
  localparam logic [STEP_W-1:0] GRID_STEP_RST = 8'd20;
  localparam logic [PX_W-1:0]   DEFAULT_X_RST = 9'd160;
  localparam logic [PY_W-1:0]   DEFAULT_Y_RST = 8'd120;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POINT,
    ST_CROSS_B,
    ST_CROSS_C,
    ST_CLOSE_A,
    ST_CLOSE_B,
    ST_CLOSE_C,
    ST_ABS,
    ST_BEST,
    ST_CHECK,
    ST_DX_GO,
    ST_DX_WAIT,
    ST_DY_GO,
    ST_DY_WAIT,
    ST_QX_GO,
    ST_QX_WAIT,
    ST_QY_GO,
    ST_QY_WAIT,
    ST_MUL_X,
    ST_MUL_Y,
    ST_OUT
  } lcc_state_t;

endpackage

// File: design/largest_contour_centroid.sv
// ----------------------------------------------------------------------------
// largest_contour_centroid: centroid of the largest contour of a frame
// Shoelace area per contour, best contour kept, mean point quantized.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one contour point per item, with marks for
//   the last point of a contour and of a frame. in_stall is high while the
//   sequencer works on the accepted item: ST_POINT alone for the first
//   point of a contour, ST_POINT to ST_CROSS_C for a following point, and
//   ST_CLOSE_A to ST_BEST in addition when it ends a contour. A frame end
//   then runs ST_CHECK, four divides, ST_MUL_X, ST_MUL_Y and ST_OUT when a
//   contour qualifies, or ST_CHECK and ST_OUT when none does. The rate is
//   set by the single shared 9x8 multiplier and the bit-serial divider.
//   One result item per frame leaves on the output channel from an output
//   register; new points are taken while it waits. A frame end that
//   finishes while the previous result is still stalled waits for it.
//   Configuration writes on cfg_we are applied in the same cycle edge;
//   they must be made only while the block is idle, which it does not enforce.
//   Synchronous reset clears all contour and frame state, drops out_valid
//   and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module largest_contour_centroid #(
  parameter int MAX_POINTS = lcc_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [lcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcc_pkg::AREA_W-1:0]   cfg_data,
  // point input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lcc_pkg::PX_W-1:0]     in_point_x,
  input  logic [lcc_pkg::PY_W-1:0]     in_point_y,
  input  logic                         in_contour_end,
  input  logic                         in_frame_end,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcc_pkg::PX_W-1:0]     out_center_x,
  output logic [lcc_pkg::PY_W-1:0]     out_center_y,
  output logic                         out_found
);

  import lcc_pkg::*;

  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int SUM_X_W  = PX_W + $clog2(MAX_POINTS);
  localparam int SUM_Y_W  = PY_W + $clog2(MAX_POINTS);
  localparam int CROSS_W  = PROD_W + 1 + $clog2(MAX_POINTS + 1);
  localparam int DIV_DW   = SUM_X_W;
  localparam int DIV_VW   = (CNT_W > STEP_W) ? CNT_W : STEP_W;

  lcc_state_t state_r, state_nxt;

  // configuration registers
  logic [AREA_W-1:0] min_area_r;
  logic [STEP_W-1:0] grid_step_r;
  logic [PX_W-1:0]   default_x_r;
  logic [PY_W-1:0]   default_y_r;

  // latched item
  logic [PX_W-1:0] x_r;
  logic [PY_W-1:0] y_r;
  logic            close_r;
  logic            fend_r;

  // current contour
  logic [PX_W-1:0]           first_x_r, prev_x_r;
  logic [PY_W-1:0]           first_y_r, prev_y_r;
  logic signed [CROSS_W-1:0] cross_r;
  logic [SUM_X_W-1:0]        sum_x_r;
  logic [SUM_Y_W-1:0]        sum_y_r;
  logic [CNT_W-1:0]          cnt_r;

  // best contour of the frame
  logic [CROSS_W-1:0] best_area_r;
  logic [SUM_X_W-1:0] best_sx_r;
  logic [SUM_Y_W-1:0] best_sy_r;
  logic [CNT_W-1:0]   best_cnt_r;
  logic               have_best_r;

  // result path
  logic [PX_W-1:0] mean_x_r, qx_r, res_x_r;
  logic [PY_W-1:0] mean_y_r, qy_r;
  logic            found_r;

  // output register
  logic            out_valid_r;
  logic [PX_W-1:0] out_x_r;
  logic [PY_W-1:0] out_y_r;
  logic            out_found_r;

  // shared multiplier
  logic [PX_W-1:0]   mul_a;
  logic [PY_W-1:0]   mul_b;
  logic              mul_en;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_r;
  logic signed [CROSS_W-1:0] prod_ext;

  // shared divider
  logic              div_start;
  logic [DIV_DW-1:0] div_dividend;
  logic [DIV_VW-1:0] div_divisor;
  logic              div_done;
  logic [DIV_DW-1:0] div_quo;

  logic [STEP_W-1:0]  step;
  logic               in_acc;
  logic               out_free;
  logic [CROSS_W-1:0] area;
  logic               qualifies;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign step      = (grid_step_r == '0) ? STEP_W'(1) : grid_step_r;
  assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_ext  = $signed(CROSS_W'(prod_r));
  assign area      = $unsigned(cross_r);
  assign qualifies = (best_cnt_r != '0) && (best_area_r > CROSS_W'({min_area_r, 1'b0}));

  lcc_div #(
    .DW(DIV_DW),
    .VW(DIV_VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, multiplier and divider operands
  always_comb begin
    state_nxt    = state_r;
    mul_a        = '0;
    mul_b        = '0;
    mul_en       = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_POINT;
      end
      ST_POINT: begin
        if (cnt_r != '0 && cnt_r < CNT_W'(MAX_POINTS)) begin
          mul_a     = prev_x_r;
          mul_b     = y_r;
          mul_en    = 1'b1;
          state_nxt = ST_CROSS_B;
        end else begin
          state_nxt = close_r ? ST_CLOSE_A : ST_IDLE;
        end
      end
      ST_CROSS_B: begin
        mul_a     = x_r;
        mul_b     = prev_y_r;
        mul_en    = 1'b1;
        state_nxt = ST_CROSS_C;
      end
      ST_CROSS_C: begin
        state_nxt = close_r ? ST_CLOSE_A : ST_IDLE;
      end
      ST_CLOSE_A: begin
        mul_a     = prev_x_r;
        mul_b     = first_y_r;
        mul_en    = 1'b1;
        state_nxt = ST_CLOSE_B;
      end
      ST_CLOSE_B: begin
        mul_a     = first_x_r;
        mul_b     = prev_y_r;
        mul_en    = 1'b1;
        state_nxt = ST_CLOSE_C;
      end
      ST_CLOSE_C: state_nxt = ST_ABS;
      ST_ABS:     state_nxt = ST_BEST;
      ST_BEST:    state_nxt = fend_r ? ST_CHECK : ST_IDLE;
      ST_CHECK:   state_nxt = qualifies ? ST_DX_GO : ST_OUT;
      ST_DX_GO: begin
        div_start    = 1'b1;
        div_dividend = best_sx_r;
        div_divisor  = DIV_VW'(best_cnt_r);
        state_nxt    = ST_DX_WAIT;
      end
      ST_DX_WAIT: if (div_done) state_nxt = ST_DY_GO;
      ST_DY_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_DW'(best_sy_r);
        div_divisor  = DIV_VW'(best_cnt_r);
        state_nxt    = ST_DY_WAIT;
      end
      ST_DY_WAIT: if (div_done) state_nxt = ST_QX_GO;
      ST_QX_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_DW'(mean_x_r);
        div_divisor  = DIV_VW'(step);
        state_nxt    = ST_QX_WAIT;
      end
      ST_QX_WAIT: if (div_done) state_nxt = ST_QY_GO;
      ST_QY_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_DW'(mean_y_r);
        div_divisor  = DIV_VW'(step);
        state_nxt    = ST_QY_WAIT;
      end
      ST_QY_WAIT: if (div_done) state_nxt = ST_MUL_X;
      ST_MUL_X: begin
        mul_a     = qx_r;
        mul_b     = step;
        mul_en    = 1'b1;
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        mul_a     = PX_W'(qy_r);
        mul_b     = step;
        mul_en    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_area_r  <= MIN_AREA_RST;
      grid_step_r <= GRID_STEP_RST;
      default_x_r <= DEFAULT_X_RST;
      default_y_r <= DEFAULT_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_AREA:  min_area_r  <= cfg_data;
        CFG_GRID_STEP: grid_step_r <= cfg_data[STEP_W-1:0];
        CFG_DEFAULT_X: default_x_r <= cfg_data[PX_W-1:0];
        CFG_DEFAULT_Y: default_y_r <= cfg_data[PY_W-1:0];
        default: ;
      endcase
    end
  end

  // product register, loaded only when the multiplier is in use
  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= prod;
  end

  // item latch
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r     <= in_point_x;
      y_r     <= in_point_y;
      close_r <= in_contour_end || in_frame_end;
      fend_r  <= in_frame_end;
    end
  end

  // contour and frame accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      cross_r     <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      cnt_r       <= '0;
      best_area_r <= '0;
      best_sx_r   <= '0;
      best_sy_r   <= '0;
      best_cnt_r  <= '0;
      have_best_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      unique case (state_r)
        // first point of a contour
        ST_POINT: begin
          if (cnt_r == '0) begin
            first_x_r <= x_r;
            first_y_r <= y_r;
            prev_x_r  <= x_r;
            prev_y_r  <= y_r;
            sum_x_r   <= SUM_X_W'(x_r);
            sum_y_r   <= SUM_Y_W'(y_r);
            cnt_r     <= CNT_W'(1);
          end
        end
        ST_CROSS_B: cross_r <= cross_r + prod_ext;
        // following point: finish cross term and advance
        ST_CROSS_C: begin
          cross_r  <= cross_r - prod_ext;
          prev_x_r <= x_r;
          prev_y_r <= y_r;
          sum_x_r  <= sum_x_r + SUM_X_W'(x_r);
          sum_y_r  <= sum_y_r + SUM_Y_W'(y_r);
          cnt_r    <= cnt_r + CNT_W'(1);
        end
        // closing edge back to the first point
        ST_CLOSE_B: cross_r <= cross_r + prod_ext;
        ST_CLOSE_C: cross_r <= cross_r - prod_ext;
        ST_ABS: begin
          if (cross_r[CROSS_W-1]) cross_r <= -cross_r;
        end
        // keep the first contour of largest area
        ST_BEST: begin
          if (!have_best_r || area > best_area_r) begin
            best_area_r <= area;
            best_sx_r   <= sum_x_r;
            best_sy_r   <= sum_y_r;
            best_cnt_r  <= cnt_r;
            have_best_r <= 1'b1;
          end
          first_x_r <= '0;
          first_y_r <= '0;
          prev_x_r  <= '0;
          prev_y_r  <= '0;
          cross_r   <= '0;
          sum_x_r   <= '0;
          sum_y_r   <= '0;
          cnt_r     <= '0;
        end
        ST_CHECK: found_r <= qualifies;
        // frame done: clear best contour
        ST_OUT: begin
          if (out_free) begin
            best_area_r <= '0;
            best_sx_r   <= '0;
            best_sy_r   <= '0;
            best_cnt_r  <= '0;
            have_best_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // quotients and quantized coordinates
  always_ff @(posedge clk) begin
    if (state_r == ST_DX_WAIT && div_done) mean_x_r <= div_quo[PX_W-1:0];
    if (state_r == ST_DY_WAIT && div_done) mean_y_r <= div_quo[PY_W-1:0];
    if (state_r == ST_QX_WAIT && div_done) qx_r     <= div_quo[PX_W-1:0];
    if (state_r == ST_QY_WAIT && div_done) qy_r     <= div_quo[PY_W-1:0];
    if (state_r == ST_MUL_Y)               res_x_r  <= prod_r[PX_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_x_r     <= found_r ? res_x_r : default_x_r;
      out_y_r     <= found_r ? prod_r[PY_W-1:0] : default_y_r;
      out_found_r <= found_r;
    end
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_center_x = out_x_r;
  assign out_center_y = out_y_r;
  assign out_found    = out_found_r;

endmodule

// File: design/lcc_div.sv
// ----------------------------------------------------------------------------
// lcc_div: restoring divider
// Unsigned division, one quotient bit per cycle from start until done.
// ----------------------------------------------------------------------------
module lcc_div #(
  parameter int DW = 21,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [VW:0]   trial;
  logic          fits;
  logic [VW-1:0] rem_nxt;

  // one restoring step
  always_comb begin
    trial   = {rem_r, quo_r[DW-1]};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: design/lcc_checker.sv
// ----------------------------------------------------------------------------
// lcc_checker: port-level checks for the largest contour centroid block
// Watches the channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module lcc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_we,
  input logic [lcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [lcc_pkg::AREA_W-1:0]    cfg_data,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [lcc_pkg::PX_W-1:0]      in_point_x,
  input logic [lcc_pkg::PY_W-1:0]      in_point_y,
  input logic                          in_contour_end,
  input logic                          in_frame_end,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lcc_pkg::PX_W-1:0]      out_center_x,
  input logic [lcc_pkg::PY_W-1:0]      out_center_y,
  input logic                          out_found
);

  import lcc_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_center_x)
      && $stable(out_center_y) && $stable(out_found))
    else $error("stalled result item changed");

  // reset drops the result
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // every accepted item raises in_stall, so no two items are taken back to back
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // a new result appears as the sequencer returns to idle
  a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result posted while sequencer busy");

endmodule

bind largest_contour_centroid lcc_checker u_lcc_checker (.*);
